@@ rtl/smd_pkg.sv @@
package smd_pkg;

  localparam int unsigned IdLength = 32;

  localparam int unsigned MaxLenW = 17;
  localparam logic [MaxLenW-1:0] MaxLenReset = 17'h1_0000;

  localparam logic [31:0] CmdEndBuffer = 32'hFFFF_FFFE;
  localparam logic [31:0] CmdEndStream = 32'hFFFF_FFFF;

  localparam int unsigned CmdBytes = 4;

  typedef enum logic [2:0] {
    KindPayload = 3'd0,
    KindId      = 3'd1,
    KindEos     = 3'd2,
    KindEob     = 3'd3,
    KindErr     = 3'd4
  } kind_e;

  // one result on its way from the front end to the output register
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
    logic       have;
  } item_t;

endpackage

@@ rtl/stream_mux_deframer_top.sv @@
// channel   | handshake               | payload
// ----------+-------------------------+----------------------------------------------
// input     | in_valid_i / in_ready_o | rx_byte_i
// output    | out_valid_o/out_ready_i | kind_o, data_byte_o, id_last_o, stream_changed_o
// config    | psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
// one byte per cycle while in_ready_o is high; each result passes the stage-one register (identifier memory read
// stage) and then the output register. Bytes that give no result (command bytes, length commands) only update state
// reset clears all control state; the identifier memory is not cleared
// input is taken whenever the result stage can move on, so a full output register
// still lets one more byte in

module stream_mux_deframer_top #(
  parameter int unsigned ID_LENGTH = smd_pkg::IdLength
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        id_last_o,
  output logic        stream_changed_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (ID_LENGTH > 1) ? $clog2(ID_LENGTH) : 1;

  logic [smd_pkg::MaxLenW-1:0] max_len_q;
  logic                        accept;
  logic                        s1_ready;
  logic                        emit;
  smd_pkg::item_t              item;
  logic                        mem_en;
  logic [IdxW-1:0]             mem_addr;
  logic [7:0]                  mem_rdata;
  logic                        reg_sel;

  // max chunk length register, selected by paddr[2] == 0 (byte addresses 0 to 3)
  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(32 - smd_pkg::MaxLenW){1'b0}}, max_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= smd_pkg::MaxLenReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      max_len_q <= pwdata[smd_pkg::MaxLenW-1:0];
    end
  end

  assign in_ready_o = s1_ready;
  assign accept     = in_valid_i && s1_ready;

  smd_ctrl #(
    .ID_LENGTH (ID_LENGTH),
    .IdxW      (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .max_len_i  (max_len_q),
    .item_o     (item),
    .emit_o     (emit),
    .mem_en_o   (mem_en),
    .mem_addr_o (mem_addr)
  );

  smd_id_mem #(
    .Depth (ID_LENGTH),
    .AddrW (IdxW)
  ) u_id_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .addr_i  (mem_addr),
    .wdata_i (rx_byte_i),
    .rdata_o (mem_rdata)
  );

  smd_out u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (accept && emit),
    .item_i           (item),
    .rdata_i          (mem_rdata),
    .s1_ready_o       (s1_ready),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .id_last_o        (id_last_o),
    .stream_changed_o (stream_changed_o)
  );

endmodule

@@ rtl/smd_id_mem.sv @@
module smd_id_mem #(
  parameter int unsigned Depth = smd_pkg::IdLength,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  // read-first: the old identifier byte comes out while the new one goes in
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/smd_ctrl.sv @@
module smd_ctrl #(
  parameter int unsigned ID_LENGTH = smd_pkg::IdLength,
  parameter int unsigned IdxW      = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic [smd_pkg::MaxLenW-1:0]  max_len_i,
  output smd_pkg::item_t               item_o,
  output logic                         emit_o,
  output logic                         mem_en_o,
  output logic [IdxW-1:0]              mem_addr_o
);

  localparam int unsigned CntW = (IdxW > 2) ? IdxW : 2;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ID_LENGTH - 1);
  localparam logic [CntW-1:0] LastCmdIdx = CntW'(smd_pkg::CmdBytes - 1);

  typedef enum logic [1:0] {
    PhId,
    PhCmd,
    PhPay,
    PhBad
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [CntW-1:0]               idx_q, idx_d;
  logic [23:0]                   cmd_q, cmd_d;
  logic [smd_pkg::MaxLenW-1:0]   left_q, left_d;
  logic                          have_q, have_d;
  logic [31:0]                   cmd;
  logic                          len_ok;
  logic                          id_last;

  assign cmd        = {cmd_q, rx_byte_i};
  assign len_ok     = (cmd[31:smd_pkg::MaxLenW] == '0) && (cmd[smd_pkg::MaxLenW-1:0] != '0) &&
                      (cmd[smd_pkg::MaxLenW-1:0] <= max_len_i);
  assign id_last    = (idx_q[IdxW-1:0] == LastIdx);
  assign mem_addr_o = idx_q[IdxW-1:0];

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    left_d      = left_q;
    have_d      = have_q;
    emit_o      = 1'b0;
    mem_en_o    = 1'b0;
    item_o.kind = smd_pkg::KindErr;
    item_o.data = '0;
    item_o.last = 1'b0;
    item_o.have = have_q;
    unique case (phase_q)
      PhId: begin
        mem_en_o    = accept_i;
        emit_o      = 1'b1;
        item_o.kind = smd_pkg::KindId;
        item_o.data = rx_byte_i;
        item_o.last = id_last;
        if (id_last) begin
          have_d  = 1'b1;
          idx_d   = '0;
          phase_d = PhCmd;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      PhCmd: begin
        if (idx_q != LastCmdIdx) begin
          cmd_d = {cmd_q[15:0], rx_byte_i};
          idx_d = idx_q + CntW'(1);
        end else begin
          cmd_d = '0;
          idx_d = '0;
          if (cmd == smd_pkg::CmdEndBuffer) begin
            phase_d     = PhId;
            emit_o      = 1'b1;
            item_o.kind = smd_pkg::KindEob;
          end else if (cmd == smd_pkg::CmdEndStream) begin
            emit_o      = 1'b1;
            item_o.kind = smd_pkg::KindEos;
          end else if (len_ok) begin
            left_d  = cmd[smd_pkg::MaxLenW-1:0];
            phase_d = PhPay;
          end else begin
            phase_d     = PhBad;
            emit_o      = 1'b1;
            item_o.kind = smd_pkg::KindErr;
          end
        end
      end
      PhPay: begin
        emit_o      = 1'b1;
        item_o.kind = smd_pkg::KindPayload;
        item_o.data = rx_byte_i;
        if (left_q != '0) begin
          left_d = left_q - smd_pkg::MaxLenW'(1);
        end
        if (left_d == '0) begin
          phase_d = PhCmd;
        end
      end
      PhBad: begin
        emit_o      = 1'b1;
        item_o.kind = smd_pkg::KindErr;
      end
      default: begin
        phase_d = PhBad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhId;
      idx_q   <= '0;
      cmd_q   <= '0;
      left_q  <= '0;
      have_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      cmd_q   <= cmd_d;
      left_q  <= left_d;
      have_q  <= have_d;
    end
  end

endmodule

@@ rtl/smd_out.sv @@
module smd_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  smd_pkg::item_t  item_i,
  input  logic [7:0]      rdata_i,
  output logic            s1_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic            id_last_o,
  output logic            stream_changed_o
);

  logic           s1_valid_q;
  smd_pkg::item_t s1_q;
  logic           mismatch_q;
  logic           out_valid_q;
  logic [2:0]     kind_q;
  logic [7:0]     data_q;
  logic           last_q;
  logic           changed_q;
  logic           out_space;
  logic           is_id;
  logic           diff;
  logic           changed;

  assign out_space  = !out_valid_q || out_ready_i;
  assign s1_ready_o = !s1_valid_q || out_space;
  assign is_id      = (s1_q.kind == smd_pkg::KindId);
  assign diff       = is_id && s1_q.have && (rdata_i != s1_q.data);
  assign changed    = is_id && s1_q.last && s1_q.have && (mismatch_q || diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      mismatch_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready_o) begin
        s1_valid_q <= load_i;
      end
      if (out_space) begin
        out_valid_q <= s1_valid_q;
      end
      // mismatch over the identifier bytes seen so far
      if (s1_valid_q && out_space && is_id) begin
        mismatch_q <= s1_q.last ? 1'b0 : (mismatch_q || diff);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready_o && load_i) begin
      s1_q <= item_i;
    end
    if (out_space && s1_valid_q) begin
      kind_q    <= s1_q.kind;
      data_q    <= s1_q.data;
      last_q    <= s1_q.last;
      changed_q <= changed;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign data_byte_o      = data_q;
  assign id_last_o        = last_q;
  assign stream_changed_o = changed_q;

endmodule

@@ tb/stream_mux_deframer_top_tb.sv @@
module stream_mux_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [2:0] RegMaxChunk = 3'd0;
  localparam int unsigned PhaseBytes = 140;

  typedef struct packed {
    smd_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
    logic           changed;
  } result_t;

  typedef enum logic [1:0] {
    LinkId,
    LinkCmd,
    LinkPayload,
    LinkBroken
  } link_phase_e;

  class deframe_scoreboard;
    logic [16:0]  max_len;
    link_phase_e  phase;
    int unsigned  idx;
    logic [23:0]  cmd_head;
    logic [16:0]  left;
    logic [7:0]   id_mem [smd_pkg::IdLength];
    bit           mismatch;
    bit           have_id;
    result_t      expected_q [$];
    int unsigned  errors;
    int unsigned  checked;

    function new();
      max_len  = smd_pkg::MaxLenReset;
      phase    = LinkId;
      idx      = 0;
      cmd_head = '0;
      left     = '0;
      mismatch = 1'b0;
      have_id  = 1'b0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_max_len(logic [16:0] v);
      max_len = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // works out what one accepted byte must produce
    function void note_byte(logic [7:0] b);
      result_t     r;
      logic [31:0] cmd;
      int unsigned i;
      r.kind    = smd_pkg::KindErr;
      r.data    = 8'h00;
      r.last    = 1'b0;
      r.changed = 1'b0;
      case (phase)
        LinkId: begin
          i = (idx >= smd_pkg::IdLength) ? smd_pkg::IdLength - 1 : idx;
          if (have_id && id_mem[i] != b) mismatch = 1'b1;
          id_mem[i] = b;
          r.kind = smd_pkg::KindId;
          r.data = b;
          if (i == smd_pkg::IdLength - 1) begin
            r.last    = 1'b1;
            r.changed = have_id && mismatch;
            have_id   = 1'b1;
            mismatch  = 1'b0;
            idx       = 0;
            phase     = LinkCmd;
          end else begin
            idx = i + 1;
          end
          expected_q.push_back(r);
        end
        LinkCmd: begin
          if (idx < smd_pkg::CmdBytes - 1) begin
            cmd_head = {cmd_head[15:0], b};
            idx++;
          end else begin
            cmd      = {cmd_head, b};
            cmd_head = '0;
            idx      = 0;
            if (cmd == smd_pkg::CmdEndBuffer) begin
              phase  = LinkId;
              r.kind = smd_pkg::KindEob;
              expected_q.push_back(r);
            end else if (cmd == smd_pkg::CmdEndStream) begin
              r.kind = smd_pkg::KindEos;
              expected_q.push_back(r);
            end else if (cmd != 0 && cmd <= {15'd0, max_len}) begin
              left  = cmd[16:0];
              phase = LinkPayload;
            end else begin
              phase = LinkBroken;
              expected_q.push_back(r);
            end
          end
        end
        LinkPayload: begin
          if (left != 0) left--;
          if (left == 0) phase = LinkCmd;
          r.kind = smd_pkg::KindPayload;
          r.data = b;
          expected_q.push_back(r);
        end
        default: begin
          expected_q.push_back(r);
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d data %02h last %b changed %b",
                 $time, got.kind, got.data, got.last, got.changed);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.kind !== want.kind || got.data !== want.data ||
          got.last !== want.last || got.changed !== want.changed) begin
        errors++;
        $display("%0t: expected kind %0d data %02h last %b changed %b,",
                 $time, want.kind, want.data, want.last, want.changed,
                 " got kind %0d data %02h last %b changed %b",
                 got.kind, got.data, got.last, got.changed);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic        id_last_o;
  logic        stream_changed_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = RegMaxChunk;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  deframe_scoreboard board;
  logic [7:0]  link_bytes [$];
  logic [7:0]  prev_id [smd_pkg::IdLength];
  bit          have_prev_id = 1'b0;
  bit          need_id = 1'b1;
  bit          quiet = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  stream_mux_deframer_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .id_last_o       (id_last_o),
    .stream_changed_o(stream_changed_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        board.check_result({smd_pkg::kind_e'(kind_o), data_byte_o, id_last_o,
                            stream_changed_o});
      out_ready_i <= quiet || ($urandom_range(0, 99) >= 6);
    end
  end

  function automatic void push_word(logic [31:0] w);
    link_bytes.push_back(w[31:24]);
    link_bytes.push_back(w[23:16]);
    link_bytes.push_back(w[15:8]);
    link_bytes.push_back(w[7:0]);
  endfunction

  // 0 repeat the last identifier, 1 change one byte, 2 fresh identifier
  function automatic void push_id(int unsigned mode);
    int unsigned j;
    if (!have_prev_id) mode = 2;
    if (mode == 1) begin
      j = $urandom_range(0, smd_pkg::IdLength - 1);
      prev_id[j] = prev_id[j] ^ 8'($urandom_range(1, 255));
    end else if (mode == 2) begin
      for (int k = 0; k < smd_pkg::IdLength; k++) prev_id[k] = 8'($urandom_range(0, 255));
    end
    for (int k = 0; k < smd_pkg::IdLength; k++) link_bytes.push_back(prev_id[k]);
    have_prev_id = 1'b1;
    need_id = 1'b0;
  endfunction

  function automatic void push_chunk(int unsigned len);
    push_word(32'(len));
    repeat (len) link_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic int unsigned pick_len(int unsigned cap);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4 && cap <= 400) return cap;
    if (r < 10) return $urandom_range(1, (cap < 300) ? cap : 300);
    return $urandom_range(1, (cap < 8) ? cap : 8);
  endfunction

  function automatic void gen_group(int unsigned cap);
    int unsigned n;
    if (need_id) push_id($urandom_range(0, 2));
    n = $urandom_range(1, 5);
    repeat (n) begin
      if ($urandom_range(0, 99) < 15) push_word(smd_pkg::CmdEndStream);
      else push_chunk(pick_len(cap));
    end
    if ($urandom_range(0, 99) < 75) begin
      push_word(smd_pkg::CmdEndBuffer);
      need_id = 1'b1;
    end
  endfunction

  task automatic send_bytes(input int unsigned n);
    logic [7:0]  b;
    int unsigned gap;
    repeat (n) begin
      b = link_bytes.pop_front();
      if (!quiet && $urandom_range(0, 99) < 2) begin
        gap = $urandom_range(1, 5);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      rx_byte_i  <= b;
      do @(posedge clk_i); while (!in_ready_o);
      board.note_byte(b);
      bytes_sent++;
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (board.pending() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_rw(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= RegMaxChunk;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_max_chunk(input logic [16:0] want);
    logic [31:0] rd;
    apb_rw(1'b0, '0, rd);
    if (rd !== {15'd0, want}) begin
      board.errors++;
      $display("%0t: max_chunk_length read expected %0d, got %0d", $time, want, rd);
    end
  endtask

  task automatic set_max_chunk(input logic [16:0] v);
    logic [31:0] rd;
    apb_rw(1'b1, {15'd0, v}, rd);
    board.set_max_len(v);
    read_max_chunk(v);
  endtask

  initial begin
    int unsigned plan [6];
    int unsigned cap;
    int unsigned tail;
    int unsigned err_case;
    logic [31:0] bad;

    board = new();
    plan[0] = 1;
    plan[1] = 65536;
    plan[2] = $urandom_range(2, 600);
    plan[3] = 17'h1_FFFF;
    plan[4] = $urandom_range(1, 65536);
    plan[5] = 65536;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    read_max_chunk(smd_pkg::MaxLenReset);

    // directed: extreme identifier bytes, both markers, short chunks,
    // a repeated identifier and one that differs in a single byte
    for (int k = 0; k < smd_pkg::IdLength; k++)
      prev_id[k] = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'(k * 37);
    have_prev_id = 1'b1;
    push_id(0);
    push_word(smd_pkg::CmdEndStream);
    push_word(32'd2);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFF);
    push_chunk(1);
    push_word(smd_pkg::CmdEndBuffer);
    push_id(0);
    push_word(smd_pkg::CmdEndBuffer);
    push_id(1);
    need_id = 1'b0;
    send_bytes(link_bytes.size());
    drain();

    // random groups; a few bytes may carry over a register write
    for (int p = 0; p < 6; p++) begin
      set_max_chunk(17'(plan[p]));
      cap = (p < 5 && plan[p + 1] < plan[p]) ? plan[p + 1] : plan[p];
      quiet = (p == 3);
      while (link_bytes.size() < PhaseBytes) gen_group(cap);
      tail = (p < 5) ? $urandom_range(0, 6) : 0;
      send_bytes(link_bytes.size() - tail);
      drain();
    end
    quiet = 1'b0;

    // one bad command, after which the block stays broken
    err_case = $urandom_range(0, 3);
    if (err_case == 3) set_max_chunk(17'd0);
    if (need_id) push_id($urandom_range(0, 2));
    case (err_case)
      0:       bad = 32'd0;
      1:       bad = 32'h8000_0000 | 32'($urandom_range(0, 32'h7FFF_FFFD));
      2:       bad = {15'd0, board.max_len} + 32'd1;
      default: bad = 32'd1;
    endcase
    push_word(bad);
    repeat (8) link_bytes.push_back(8'($urandom_range(0, 255)));
    send_bytes(link_bytes.size());
    drain();

    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: %0d expected results never arrived", $time, board.pending());
    end
    $display("sent %0d link bytes, checked %0d results across 7 max-length settings",
             bytes_sent, board.checked);
    $display("closing bad command case %0d, %0d errors", err_case, board.errors);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
